FILE: rtl/hvps_pkg.sv
// Package for the HV precharge / ready-to-drive sequencer.
// Holds item structs, the one-hot state type, the held-level struct and register indexes.
// No dependencies.
package hvps_pkg;

    localparam int CfgIdxW = 8;

    localparam logic [CfgIdxW-1:0] CfgPrechargeMax = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgPrechargeMin = 8'd1;
    localparam logic [CfgIdxW-1:0] CfgUpdatePeriod = 8'd2;
    localparam logic [CfgIdxW-1:0] CfgRtdHold      = 8'd3;

    localparam logic [15:0] PrechargeMaxRst = 16'd5000;
    localparam logic [15:0] PrechargeMinRst = 16'd1000;
    localparam logic [9:0]  UpdatePeriodRst = 10'd10;
    localparam logic [15:0] RtdHoldRst      = 16'd1000;

    localparam logic [7:0] RtdCountMax = 8'd255;

    localparam logic [1:0] RtdsNone = 2'd0;
    localparam logic [1:0] RtdsOn   = 2'd1;
    localparam logic [1:0] RtdsOff  = 2'd2;

    // all_flags bits
    localparam int AllPrecharged = 0;
    localparam int AllDcEcho     = 1;
    localparam int AllDcQuit     = 2;
    localparam int AllOnEcho     = 3;
    localparam int AllOnQuit     = 4;
    // any_flags bits
    localparam int AnyOnEcho = 0;
    localparam int AnyOnQuit = 1;
    localparam int AnyDcEcho = 2;
    localparam int AnyDcQuit = 3;

    typedef enum logic [6:0] {
        ST_NOT_READY   = 7'b000_0001,
        ST_POWERED     = 7'b000_0010,
        ST_PRECHARGING = 7'b000_0100,
        ST_WAIT        = 7'b000_1000,
        ST_STANDBY     = 7'b001_0000,
        ST_RUN         = 7'b010_0000,
        ST_SHUTDOWN    = 7'b100_0000
    } t_veh_state;

    localparam logic [2:0] CodeNotReady    = 3'd0;
    localparam logic [2:0] CodePowered     = 3'd1;
    localparam logic [2:0] CodePrecharging = 3'd2;
    localparam logic [2:0] CodeWait        = 3'd3;
    localparam logic [2:0] CodeStandby     = 3'd4;
    localparam logic [2:0] CodeRun         = 3'd5;
    localparam logic [2:0] CodeShutdown    = 3'd6;

    typedef struct packed {
        logic       main_led;
        logic       timeouts_active;
        logic       dc_on;
        logic       inverter_on;
        logic       inverter_enable;
        logic       activate_relay;
        logic       precharge_relay;
        logic       interlock_relay;
    } t_levels;

    typedef struct packed {
        t_veh_state  state;
        logic [31:0] precharge_start;
        logic [7:0]  rtd_count;
        t_levels     levels;
    } t_seq_state;

    typedef struct packed {
        logic [15:0] precharge_max_ms;
        logic [15:0] precharge_min_ms;
        logic [9:0]  update_period_ms;
        logic [15:0] rtd_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        tsms;
        logic        rtd_button;
        logic        charge_error_cleared;
        logic        inverters_ready;
        logic [4:0]  all_flags;
        logic [3:0]  any_flags;
        logic        no_hard_fault;
    } t_in_item;

    typedef struct packed {
        logic [2:0] vehicle_state;
        logic       interlock_relay;
        logic       precharge_relay;
        logic       activate_relay;
        logic       inverter_enable;
        logic       inverter_on;
        logic       dc_on;
        logic       timeouts_active;
        logic       main_led;
        logic       precharge_timeout;
        logic [1:0] rtds_request;
        logic       zero_torque;
    } t_out_item;

    function automatic logic [2:0] state_code(input t_veh_state s);
        logic [2:0] c;
        case (s)
            ST_NOT_READY:   c = CodeNotReady;
            ST_POWERED:     c = CodePowered;
            ST_PRECHARGING: c = CodePrecharging;
            ST_WAIT:        c = CodeWait;
            ST_STANDBY:     c = CodeStandby;
            ST_RUN:         c = CodeRun;
            ST_SHUTDOWN:    c = CodeShutdown;
            default:        c = CodeNotReady;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/hvps_step.sv
// Next-state and result logic for one item of the sequencer.
// Purely combinational; depends on hvps_pkg.
module hvps_step (
    input  hvps_pkg::t_seq_state i_cur,
    input  hvps_pkg::t_cfg       i_cfg,
    input  hvps_pkg::t_in_item   i_item,
    output hvps_pkg::t_seq_state o_nxt,
    output hvps_pkg::t_out_item  o_res
);

    hvps_pkg::t_seq_state s;
    logic [31:0] elapsed;
    logic [17:0] hold_product;
    logic        timeout;
    logic [1:0]  rtds;
    logic        zero_torque;

    always_comb begin
        s            = i_cur;
        timeout      = 1'b0;
        rtds         = hvps_pkg::RtdsNone;
        zero_torque  = 1'b0;
        elapsed      = i_item.now_ms - i_cur.precharge_start;
        hold_product = 18'd0;

        if (i_item.kind) begin
            s.state = hvps_pkg::ST_SHUTDOWN;
        end else begin
            // master switch opened in any active state drops back first
            if (!i_item.tsms && (s.state == hvps_pkg::ST_POWERED ||
                    s.state == hvps_pkg::ST_PRECHARGING || s.state == hvps_pkg::ST_WAIT ||
                    s.state == hvps_pkg::ST_STANDBY || s.state == hvps_pkg::ST_RUN)) begin
                s.levels.interlock_relay = 1'b0;
                s.state                  = hvps_pkg::ST_NOT_READY;
            end
            case (s.state)
                hvps_pkg::ST_NOT_READY: begin
                    s.levels.main_led = 1'b1;
                    if (i_item.charge_error_cleared && i_item.tsms) begin
                        s.state = hvps_pkg::ST_POWERED;
                    end
                end
                hvps_pkg::ST_POWERED: begin
                    s.levels.main_led = 1'b0;
                    if (i_item.inverters_ready) begin
                        s.levels.timeouts_active = 1'b1;
                        s.state                  = hvps_pkg::ST_PRECHARGING;
                        s.precharge_start        = i_item.now_ms;
                    end
                end
                hvps_pkg::ST_PRECHARGING: begin
                    s.levels.precharge_relay = 1'b1;
                    timeout = (elapsed > {16'd0, i_cfg.precharge_max_ms});
                    if (i_item.all_flags[hvps_pkg::AllPrecharged]) begin
                        s.levels.dc_on = 1'b1;
                        if (i_item.all_flags[hvps_pkg::AllDcEcho] &&
                                i_item.all_flags[hvps_pkg::AllDcQuit] &&
                                elapsed >= {16'd0, i_cfg.precharge_min_ms}) begin
                            s.levels.interlock_relay = 1'b1;
                            s.levels.precharge_relay = 1'b0;
                            s.state                  = hvps_pkg::ST_WAIT;
                        end
                    end
                end
                hvps_pkg::ST_WAIT: begin
                    zero_torque = 1'b1;
                    if (i_item.rtd_button) begin
                        if (s.rtd_count != hvps_pkg::RtdCountMax) begin
                            s.rtd_count = s.rtd_count + 8'd1;
                        end
                    end else begin
                        s.rtd_count = 8'd0;
                    end
                    hold_product = 18'(s.rtd_count) * 18'(i_cfg.update_period_ms);
                    if (hold_product >= 18'(i_cfg.rtd_hold_ms)) begin
                        s.state = hvps_pkg::ST_STANDBY;
                        rtds    = hvps_pkg::RtdsOn;
                    end
                end
                hvps_pkg::ST_STANDBY: begin
                    rtds                     = hvps_pkg::RtdsOff;
                    s.levels.inverter_enable = 1'b1;
                    s.levels.inverter_on     = 1'b1;
                    if (i_item.all_flags[hvps_pkg::AllOnEcho] &&
                            i_item.all_flags[hvps_pkg::AllOnQuit]) begin
                        s.levels.activate_relay = 1'b1;
                        s.state                 = hvps_pkg::ST_RUN;
                    end
                end
                hvps_pkg::ST_RUN: begin
                    if (!i_item.tsms) begin
                        s.state = hvps_pkg::ST_SHUTDOWN;
                    end
                end
                hvps_pkg::ST_SHUTDOWN: begin
                    zero_torque              = 1'b1;
                    s.levels.activate_relay  = 1'b0;
                    s.levels.inverter_on     = 1'b0;
                    s.levels.interlock_relay = 1'b0;
                    // staged release: each echo or quit flag still present holds the later steps
                    if (!i_item.any_flags[hvps_pkg::AnyOnEcho]) begin
                        s.levels.inverter_enable = 1'b0;
                        if (!i_item.any_flags[hvps_pkg::AnyOnQuit]) begin
                            s.levels.dc_on = 1'b0;
                            if (!i_item.any_flags[hvps_pkg::AnyDcEcho] &&
                                    !i_item.any_flags[hvps_pkg::AnyDcQuit] &&
                                    i_item.no_hard_fault) begin
                                s.state = hvps_pkg::ST_NOT_READY;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_nxt = s;

    always_comb begin
        o_res.vehicle_state     = hvps_pkg::state_code(s.state);
        o_res.interlock_relay   = s.levels.interlock_relay;
        o_res.precharge_relay   = s.levels.precharge_relay;
        o_res.activate_relay    = s.levels.activate_relay;
        o_res.inverter_enable   = s.levels.inverter_enable;
        o_res.inverter_on       = s.levels.inverter_on;
        o_res.dc_on             = s.levels.dc_on;
        o_res.timeouts_active   = s.levels.timeouts_active;
        o_res.main_led          = s.levels.main_led;
        o_res.precharge_timeout = timeout;
        o_res.rtds_request      = rtds;
        o_res.zero_torque       = zero_torque;
    end

endmodule

FILE: rtl/hv_precharge_ready_to_drive_sequencer.sv
// Top level of the HV precharge / ready-to-drive sequencer.
// Input register, step logic (hvps_step), result register; depends on hvps_pkg.
// The result is registered; one item per cycle while the receiver does not stall the output.
// The state registers update as an item moves from the input register to the result register.
// Reset (synchronous, active low): state not ready, levels off, registers to defaults.
module hv_precharge_ready_to_drive_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  hvps_pkg::t_in_item           i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output hvps_pkg::t_out_item          o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hvps_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]                  i_cfg_data
);

    hvps_pkg::t_cfg       r_cfg;
    hvps_pkg::t_seq_state r_st;
    hvps_pkg::t_seq_state n_st;
    hvps_pkg::t_in_item   r_in;
    logic                 r_in_valid;
    hvps_pkg::t_out_item  r_out;
    hvps_pkg::t_out_item  n_out;
    logic                 r_out_valid;
    logic                 advance;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    hvps_step u_step (
        .i_cur  (r_st),
        .i_cfg  (r_cfg),
        .i_item (r_in),
        .o_nxt  (n_st),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.precharge_max_ms <= hvps_pkg::PrechargeMaxRst;
            r_cfg.precharge_min_ms <= hvps_pkg::PrechargeMinRst;
            r_cfg.update_period_ms <= hvps_pkg::UpdatePeriodRst;
            r_cfg.rtd_hold_ms      <= hvps_pkg::RtdHoldRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hvps_pkg::CfgPrechargeMax: r_cfg.precharge_max_ms <= i_cfg_data;
                hvps_pkg::CfgPrechargeMin: r_cfg.precharge_min_ms <= i_cfg_data;
                hvps_pkg::CfgUpdatePeriod: r_cfg.update_period_ms <= i_cfg_data[9:0];
                hvps_pkg::CfgRtdHold:      r_cfg.rtd_hold_ms      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.state           <= hvps_pkg::ST_NOT_READY;
            r_st.precharge_start <= 32'd0;
            r_st.rtd_count       <= 8'd0;
            r_st.levels          <= '0;
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: test/tb_top.sv
// Testbench for hv_precharge_ready_to_drive_sequencer: directed walk through every state,
// then random traffic under several register settings, with an in-bench state predictor.
// Depends on hvps_pkg and the sequencer RTL; standalone otherwise.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hvps_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 8;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in        = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [15:0]         i_cfg_data  = '0;

    // predictor copy of the sequencer
    t_cfg        seq_cfg;
    logic [2:0]  seq_state;
    logic [31:0] seq_pc_start;
    logic [7:0]  seq_rtd_cnt;
    t_levels     seq_lv;
    t_out_item   expected_q[$];

    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          stall_req    = 0;
    int          stall_left   = 0;
    int          fault_pct    = 3;
    logic [31:0] vehicle_ms   = '0;
    int          errors       = 0;
    int          results_seen = 0;
    int          cycle_cnt    = 0;

    always #4 i_clk = ~i_clk;

    hv_precharge_ready_to_drive_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    // Advances the predicted sequencer by one item and returns the expected result.
    function automatic t_out_item step_sequencer(input t_in_item it);
        t_out_item   r;
        logic [31:0] elapsed;
        logic [31:0] hold_prod;
        r = '0;
        if (it.kind) begin
            seq_state = CodeShutdown;
        end else begin
            // master switch open drops back to not ready before the state logic
            if (seq_state > CodeNotReady && seq_state < CodeShutdown && !it.tsms) begin
                seq_lv.interlock_relay = 1'b0;
                seq_state = CodeNotReady;
            end
            case (seq_state)
                CodeNotReady: begin
                    seq_lv.main_led = 1'b1;
                    if (it.charge_error_cleared && it.tsms)
                        seq_state = CodePowered;
                end
                CodePowered: begin
                    seq_lv.main_led = 1'b0;
                    if (it.inverters_ready) begin
                        seq_lv.timeouts_active = 1'b1;
                        seq_state = CodePrecharging;
                        seq_pc_start = it.now_ms;
                    end
                end
                CodePrecharging: begin
                    elapsed = it.now_ms - seq_pc_start;
                    seq_lv.precharge_relay = 1'b1;
                    r.precharge_timeout = (elapsed > seq_cfg.precharge_max_ms);
                    if (it.all_flags[AllPrecharged]) begin
                        seq_lv.dc_on = 1'b1;
                        if (it.all_flags[AllDcEcho] && it.all_flags[AllDcQuit] &&
                            elapsed >= seq_cfg.precharge_min_ms) begin
                            seq_lv.interlock_relay = 1'b1;
                            seq_lv.precharge_relay = 1'b0;
                            seq_state = CodeWait;
                        end
                    end
                end
                CodeWait: begin
                    r.zero_torque = 1'b1;
                    if (it.rtd_button) begin
                        if (seq_rtd_cnt != RtdCountMax)
                            seq_rtd_cnt++;
                    end else begin
                        seq_rtd_cnt = '0;
                    end
                    hold_prod = seq_rtd_cnt * seq_cfg.update_period_ms;
                    if (hold_prod >= seq_cfg.rtd_hold_ms) begin
                        seq_state = CodeStandby;
                        r.rtds_request = RtdsOn;
                    end
                end
                CodeStandby: begin
                    r.rtds_request = RtdsOff;
                    seq_lv.inverter_enable = 1'b1;
                    seq_lv.inverter_on = 1'b1;
                    if (it.all_flags[AllOnEcho] && it.all_flags[AllOnQuit]) begin
                        seq_lv.activate_relay = 1'b1;
                        seq_state = CodeRun;
                    end
                end
                CodeRun: begin
                    if (!it.tsms)
                        seq_state = CodeShutdown;
                end
                CodeShutdown: begin
                    r.zero_torque = 1'b1;
                    seq_lv.activate_relay = 1'b0;
                    seq_lv.inverter_on = 1'b0;
                    seq_lv.interlock_relay = 1'b0;
                    if (!it.any_flags[AnyOnEcho]) begin
                        seq_lv.inverter_enable = 1'b0;
                        if (!it.any_flags[AnyOnQuit]) begin
                            seq_lv.dc_on = 1'b0;
                            if (!it.any_flags[AnyDcEcho] && !it.any_flags[AnyDcQuit] &&
                                it.no_hard_fault)
                                seq_state = CodeNotReady;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.vehicle_state   = seq_state;
        r.interlock_relay = seq_lv.interlock_relay;
        r.precharge_relay = seq_lv.precharge_relay;
        r.activate_relay  = seq_lv.activate_relay;
        r.inverter_enable = seq_lv.inverter_enable;
        r.inverter_on     = seq_lv.inverter_on;
        r.dc_on           = seq_lv.dc_on;
        r.timeouts_active = seq_lv.timeouts_active;
        r.main_led        = seq_lv.main_led;
        return r;
    endfunction

    function automatic t_in_item make_item(input logic kind, input logic [31:0] now,
                                           input logic tsms, input logic btn,
                                           input logic clr, input logic rdy,
                                           input logic [4:0] all, input logic [3:0] any,
                                           input logic nh);
        t_in_item it;
        it.kind                 = kind;
        it.now_ms               = now;
        it.tsms                 = tsms;
        it.rtd_button           = btn;
        it.charge_error_cleared = clr;
        it.inverters_ready      = rdy;
        it.all_flags            = all;
        it.any_flags            = any;
        it.no_hard_fault        = nh;
        return it;
    endfunction

    // Biased towards progress through the sequence; time mostly moves by about one period.
    function automatic t_in_item random_item();
        t_in_item it;
        it.kind = ($urandom_range(0, 99) < fault_pct);
        if ($urandom_range(0, 99) < 3)
            vehicle_ms = $urandom();
        else
            vehicle_ms += $urandom_range(0, 2 * seq_cfg.update_period_ms);
        it.now_ms               = vehicle_ms;
        it.tsms                 = ($urandom_range(0, 99) < 95);
        it.rtd_button           = ($urandom_range(0, 99) < 85);
        it.charge_error_cleared = ($urandom_range(0, 99) < 70);
        it.inverters_ready      = ($urandom_range(0, 99) < 70);
        for (int b = 0; b < 5; b++)
            it.all_flags[b] = ($urandom_range(0, 99) < 75);
        for (int b = 0; b < 4; b++)
            it.any_flags[b] = ($urandom_range(0, 99) < 30);
        it.no_hard_fault        = ($urandom_range(0, 99) < 80);
        return it;
    endfunction

    // Offers one item; valid stays up between back-to-back items.
    task automatic send_item(input t_in_item it);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        expected_q.push_back(step_sequencer(it));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CfgPrechargeMax: seq_cfg.precharge_max_ms = data;
            CfgPrechargeMin: seq_cfg.precharge_min_ms = data;
            CfgUpdatePeriod: seq_cfg.update_period_ms = data[9:0];
            CfgRtdHold:      seq_cfg.rtd_hold_ms      = data;
            default: ;
        endcase
    endtask

    // Registers change only with the block empty; unmapped indexes must be ignored.
    task automatic program_regs(input logic [15:0] pc_max, input logic [15:0] pc_min,
                                input logic [15:0] period, input logic [15:0] hold);
        wait_drained();
        write_reg(CfgPrechargeMax, pc_max);
        write_reg(CfgPrechargeMin, pc_min);
        write_reg(CfgUpdatePeriod, period);
        write_reg(CfgRtdHold, hold);
        write_reg(8'hFF, 16'($urandom()));
        write_reg(CfgIdxW'($urandom_range(4, 254)), 16'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_walk();
        // reset register values
        send_item(make_item(0, 32'd0, 0, 0, 0, 0, 5'd0, 4'd0, 0));
        send_item(make_item(1, 32'hFFFF_FFFF, 1, 1, 1, 1, 5'h1F, 4'hF, 1));
        send_item(make_item(0, 32'd0, 1, 1, 1, 1, 5'h1F, 4'hF, 1));
        // period high bits are masked off, leaving 10 ms
        program_regs(16'd100, 16'd30, 16'hFC0A, 16'd25);
        // shutdown release, one held flag at a time, then a hard fault
        send_item(make_item(0, 32'd5, 1, 0, 0, 0, 5'd0, 4'b0010, 1));
        send_item(make_item(0, 32'd6, 1, 0, 0, 0, 5'd0, 4'b1000, 1));
        send_item(make_item(0, 32'd7, 1, 0, 0, 0, 5'd0, 4'b0100, 1));
        send_item(make_item(0, 32'd8, 1, 0, 0, 0, 5'd0, 4'b0000, 0));
        send_item(make_item(0, 32'd9, 1, 0, 0, 0, 5'd0, 4'b0000, 1));
        // not ready / powered, including the master switch opening
        send_item(make_item(0, 32'd10, 0, 0, 1, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'd11, 1, 0, 1, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'd12, 1, 0, 1, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'd13, 0, 0, 1, 1, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'd14, 1, 0, 1, 0, 5'd0, 4'd0, 1));
        // precharge starts just below the wrap of the time counter
        send_item(make_item(0, 32'hFFFF_FFF0, 1, 0, 0, 1, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0020, 1, 0, 0, 0, 5'b00000, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0020, 1, 0, 0, 0, 5'b00011, 4'd0, 1));
        send_item(make_item(0, 32'hFFFF_FFFA, 1, 0, 0, 0, 5'b00111, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0100, 1, 0, 0, 0, 5'b00111, 4'd0, 1));
        // hold counter: press, release, then held long enough
        send_item(make_item(0, 32'h0000_0110, 1, 1, 0, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0120, 1, 0, 0, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0130, 1, 1, 0, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0140, 1, 1, 0, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0150, 1, 1, 0, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0160, 1, 0, 0, 0, 5'b01000, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0170, 1, 0, 0, 0, 5'b11000, 4'd0, 1));
        send_item(make_item(0, 32'h0000_0180, 0, 0, 0, 0, 5'd0, 4'd0, 1));
    endtask

    task automatic test_random_traffic(input int n_items, input logic [15:0] pc_max,
                                       input logic [15:0] pc_min, input logic [15:0] period,
                                       input logic [15:0] hold);
        program_regs(pc_max, pc_min, period, hold);
        repeat (n_items) send_item(random_item());
    endtask

    // Zero period never satisfies a non-zero hold, so the count must sit at its ceiling.
    task automatic test_hold_saturation();
        t_in_item go;
        go = make_item(0, 32'd50, 1, 1, 1, 1, 5'b00111, 4'd0, 1);
        program_regs(16'hFFFF, 16'd0, 16'd0, 16'd1);
        send_item(make_item(1, 32'd50, 1, 1, 1, 1, 5'b00111, 4'd0, 1));
        repeat (300) send_item(go);
        program_regs(16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_item(make_item(0, 32'd60, 1, 0, 0, 0, 5'd0, 4'd0, 1));
        send_item(make_item(0, 32'd70, 1, 0, 0, 0, 5'b11111, 4'd0, 1));
        send_item(make_item(1, 32'd80, 1, 0, 0, 0, 5'd0, 4'd0, 1));
    endtask

    // Long receiver stall while items keep coming, then a full drain before resuming.
    task automatic test_backpressure();
        program_regs(16'd300, 16'd50, 16'd20, 16'd60);
        stall_req = 80;
        repeat (60) send_item(random_item());
        wait_drained();
        repeat (40) send_item(random_item());
    endtask

    always @(posedge i_clk) begin
        if (stall_req != 0) begin
            stall_left = stall_req;
            stall_req  = 0;
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", results_seen));
            end else begin
                want = expected_q.pop_front();
                if (o_out.vehicle_state !== want.vehicle_state)
                    report_mismatch($sformatf("result %0d vehicle_state %0d, want %0d",
                        results_seen, o_out.vehicle_state, want.vehicle_state));
                if (o_out.interlock_relay !== want.interlock_relay)
                    report_mismatch($sformatf("result %0d interlock_relay %b, want %b",
                        results_seen, o_out.interlock_relay, want.interlock_relay));
                if (o_out.precharge_relay !== want.precharge_relay)
                    report_mismatch($sformatf("result %0d precharge_relay %b, want %b",
                        results_seen, o_out.precharge_relay, want.precharge_relay));
                if (o_out.activate_relay !== want.activate_relay)
                    report_mismatch($sformatf("result %0d activate_relay %b, want %b",
                        results_seen, o_out.activate_relay, want.activate_relay));
                if (o_out.inverter_enable !== want.inverter_enable)
                    report_mismatch($sformatf("result %0d inverter_enable %b, want %b",
                        results_seen, o_out.inverter_enable, want.inverter_enable));
                if (o_out.inverter_on !== want.inverter_on)
                    report_mismatch($sformatf("result %0d inverter_on %b, want %b",
                        results_seen, o_out.inverter_on, want.inverter_on));
                if (o_out.dc_on !== want.dc_on)
                    report_mismatch($sformatf("result %0d dc_on %b, want %b",
                        results_seen, o_out.dc_on, want.dc_on));
                if (o_out.timeouts_active !== want.timeouts_active)
                    report_mismatch($sformatf("result %0d timeouts_active %b, want %b",
                        results_seen, o_out.timeouts_active, want.timeouts_active));
                if (o_out.main_led !== want.main_led)
                    report_mismatch($sformatf("result %0d main_led %b, want %b",
                        results_seen, o_out.main_led, want.main_led));
                if (o_out.precharge_timeout !== want.precharge_timeout)
                    report_mismatch($sformatf("result %0d precharge_timeout %b, want %b",
                        results_seen, o_out.precharge_timeout, want.precharge_timeout));
                if (o_out.rtds_request !== want.rtds_request)
                    report_mismatch($sformatf("result %0d rtds_request %0d, want %0d",
                        results_seen, o_out.rtds_request, want.rtds_request));
                if (o_out.zero_torque !== want.zero_torque)
                    report_mismatch($sformatf("result %0d zero_torque %b, want %b",
                        results_seen, o_out.zero_torque, want.zero_torque));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit) begin
            $display("hv_precharge_ready_to_drive_sequencer regression: fail");
            $finish;
        end
    end

    initial begin
        seq_cfg      = '{PrechargeMaxRst, PrechargeMinRst, UpdatePeriodRst, RtdHoldRst};
        seq_state    = CodeNotReady;
        seq_pc_start = '0;
        seq_rtd_cnt  = '0;
        seq_lv       = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 35;
        rcv_idle_pct = 51;
        test_directed_walk();
        vehicle_ms = 32'hFFFF_F000;
        test_random_traffic(450, 16'd200, 16'd40, 16'd10, 16'd30);

        snd_idle_pct = 51;
        rcv_idle_pct = 35;
        // largest values everywhere; the period masks down to 1023
        test_random_traffic(200, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_hold_saturation();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_traffic(350, 16'd0, 16'd0, 16'd1, 16'd0);
        test_backpressure();

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0)
            $display("hv_precharge_ready_to_drive_sequencer regression: pass");
        else
            $display("hv_precharge_ready_to_drive_sequencer regression: fail");
        $finish;
    end

endmodule
